// ===== rtl/dkmc_pkg.sv =====
// ----------------------------------------------------------------------------
// dkmc_pkg - shared types and constants for the key mode controller
// Command codes, debounce status, remote key table and mode channel patterns.
// ----------------------------------------------------------------------------
package dkmc_pkg;

    localparam int CNT_W = 10;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 10'd20;

    // configuration register indexes
    localparam logic REG_DEBOUNCE = 1'b0;

    // key LED bits
    localparam logic [3:0] LED_NONE  = 4'h0;
    localparam logic [3:0] LED_STOP  = 4'h1;
    localparam logic [3:0] LED_MINUS = 4'h2;
    localparam logic [3:0] LED_PLUS  = 4'h4;
    localparam logic [3:0] LED_RUN   = 4'h8;
    localparam logic [3:0] LED_RESET = LED_RUN;

    // button order: start, stop, up, down
    localparam int BTN_START = 0;
    localparam int BTN_STOP  = 1;
    localparam int BTN_UP    = 2;
    localparam int BTN_DOWN  = 3;

    // translated remote codes
    localparam logic [3:0] RCODE_START = 4'd1;
    localparam logic [3:0] RCODE_UP    = 4'd2;
    localparam logic [3:0] RCODE_DOWN  = 4'd3;
    localparam logic [3:0] RCODE_STOP  = 4'd4;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_UP    = 3'd3,
        CMD_DOWN  = 3'd4
    } cmd_t;

    typedef struct packed {
        logic fire;       // reached threshold this tick
        logic lock_cur;   // lock at start of tick
        logic lock_nxt;   // lock after this tick
    } deb_stat_t;

    function automatic logic [3:0] btn_led(input logic [1:0] idx);
        logic [3:0] led;
        unique case (idx)
            2'd0:    led = LED_NONE;
            2'd1:    led = LED_STOP;
            2'd2:    led = LED_PLUS;
            default: led = LED_MINUS;
        endcase
        return led;
    endfunction

    function automatic cmd_t btn_cmd(input logic [1:0] idx);
        cmd_t c;
        unique case (idx)
            2'd0:    c = CMD_START;
            2'd1:    c = CMD_STOP;
            2'd2:    c = CMD_UP;
            default: c = CMD_DOWN;
        endcase
        return c;
    endfunction

    function automatic logic [3:0] remote_code(input logic [3:0] nib);
        logic [3:0] code;
        unique case (nib)
            4'd0:    code = 4'd0;
            4'd1:    code = 4'd1;
            4'd2:    code = 4'd2;
            4'd3:    code = 4'd10;
            4'd4:    code = 4'd3;
            4'd5:    code = 4'd15;
            4'd6:    code = 4'd6;
            4'd7:    code = 4'd7;
            4'd8:    code = 4'd14;
            4'd9:    code = 4'd9;
            4'd10:   code = 4'd4;
            4'd11:   code = 4'd5;
            4'd12:   code = 4'd8;
            4'd13:   code = 4'd12;
            4'd14:   code = 4'd11;
            default: code = 4'd13;
        endcase
        return code;
    endfunction

    function automatic logic [15:0] mode_pattern(input logic [3:0] idx);
        logic [15:0] pat;
        unique case (idx)
            4'd0:    pat = 16'h0005;
            4'd1:    pat = 16'h0010;
            4'd2:    pat = 16'h000A;
            4'd3:    pat = 16'h0020;
            4'd4:    pat = 16'h0005;
            4'd5:    pat = 16'h0040;
            4'd6:    pat = 16'h000A;
            4'd7:    pat = 16'h0020;
            4'd8:    pat = 16'h0081;
            4'd9:    pat = 16'h0200;
            4'd10:   pat = 16'h0102;
            4'd11:   pat = 16'h0400;
            4'd12:   pat = 16'h0081;
            4'd13:   pat = 16'h0800;
            4'd14:   pat = 16'h0101;
            default: pat = 16'h0400;
        endcase
        return pat;
    endfunction

endpackage

// ===== rtl/debounced_key_mode_controller_top.sv =====
// ----------------------------------------------------------------------------
// debounced_key_mode_controller_top - debounced key and remote mode selector
// Debounces four buttons and a remote nibble, runs a run/stop and mode state
// machine, and drives key LEDs and a 16-channel pattern every tick.
// ----------------------------------------------------------------------------
// Usage notes:
//   s_ channel: one transfer per millisecond tick, carrying the four
//   active-low buttons and the remote decoder nibble.
//   m_ channel: exactly one result transfer per input transfer, in order:
//   key LEDs, channel pattern and the current mode (0 while stopped).
//   The result is registered and valid the cycle after the input transfer.
//   Throughput: one tick per cycle while results are taken. The whole tick update (five debounce
//   counters, command select, mode step, table lookup) sits between the
//   input handshake and the result register, so the state recurrence
//   closes with no register inside it.
//   Stall: a pending result holds in the output register; s_ready stays
//   high as long as the result is taken in the same cycle, otherwise the
//   input waits until the result register frees.
//   Reset (aresetn low, synchronous): counters and locks clear, mode 1,
//   running, run LED on, debounce threshold 20, no result pending.
//   APB: register 0 at byte address 0 holds debounce_ticks; write only
//   while idle. pready is tied high.
// ----------------------------------------------------------------------------
module debounced_key_mode_controller_top #(
    parameter int MODE_COUNT = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // tick input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_start_key_n,
    input  logic        s_stop_key_n,
    input  logic        s_up_key_n,
    input  logic        s_down_key_n,
    input  logic [3:0]  s_remote_nibble,
    // result output
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_key_leds,
    output logic [15:0] m_channel_drive,
    output logic [4:0]  m_current_mode
);

    localparam logic [4:0] MODE_MAX = 5'(MODE_COUNT);

    // ---------------- configuration ----------------
    logic [dkmc_pkg::CNT_W-1:0] debounce_reg;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= dkmc_pkg::DEBOUNCE_RESET;
        end else if (cfg_wr && (paddr[2] == dkmc_pkg::REG_DEBOUNCE)) begin
            debounce_reg <= pwdata[dkmc_pkg::CNT_W-1:0];
        end
    end

    // only one register; anything beyond reads as zero
    assign prdata = (paddr[2] == dkmc_pkg::REG_DEBOUNCE)
                    ? {{(32-dkmc_pkg::CNT_W){1'b0}}, debounce_reg} : '0;

    // ---------------- handshake ----------------
    logic m_valid_reg;
    logic step;

    // output register frees when its result is taken this cycle
    assign s_ready = !m_valid_reg || m_ready;
    assign step    = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    // ---------------- debounce ----------------
    logic [3:0]          btn_active;
    dkmc_pkg::deb_stat_t btn_stat [4];
    dkmc_pkg::deb_stat_t rem_stat;
    logic                any_fire;

    assign btn_active = ~{s_down_key_n, s_up_key_n, s_stop_key_n, s_start_key_n};

    for (genvar g = 0; g < 4; g++) begin : g_btn
        dkmc_debounce u_btn (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .step      (step),
            .active    (btn_active[g]),
            .hold      (1'b0),
            .threshold (debounce_reg),
            .stat      (btn_stat[g])
        );
    end

    assign any_fire = btn_stat[0].fire | btn_stat[1].fire
                    | btn_stat[2].fire | btn_stat[3].fire;

    // remote is ignored on a tick where any button fired
    dkmc_debounce u_remote (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .active    (s_remote_nibble != 4'd0),
        .hold      (any_fire),
        .threshold (debounce_reg),
        .stat      (rem_stat)
    );

    // ---------------- tick update ----------------
    logic [3:0]     led_reg, led_next;
    logic [4:0]     mode_reg, mode_next;
    logic           stopped_reg, stopped_next;
    dkmc_pkg::cmd_t cmd;
    logic [3:0]     rcode;

    assign rcode = dkmc_pkg::remote_code(s_remote_nibble);

    always_comb begin
        led_next     = led_reg;
        mode_next    = mode_reg;
        stopped_next = stopped_reg;
        cmd          = dkmc_pkg::CMD_NONE;

        // button scan; last firing button wins the command
        for (int i = 0; i < 4; i++) begin
            if (!btn_active[i]) begin
                if (!rem_stat.lock_cur) begin
                    led_next = led_next & ~dkmc_pkg::btn_led(2'(i));
                end
            end else if (btn_stat[i].fire) begin
                cmd      = dkmc_pkg::btn_cmd(2'(i));
                led_next = led_next | dkmc_pkg::btn_led(2'(i));
            end
        end

        // remote
        if (!any_fire) begin
            if (s_remote_nibble == 4'd0) begin
                priority if (!btn_stat[dkmc_pkg::BTN_STOP].lock_nxt) begin
                    led_next = led_next & ~dkmc_pkg::LED_STOP;
                end else if (!btn_stat[dkmc_pkg::BTN_UP].lock_nxt) begin
                    led_next = led_next & ~dkmc_pkg::LED_PLUS;
                end else if (!btn_stat[dkmc_pkg::BTN_DOWN].lock_nxt) begin
                    led_next = led_next & ~dkmc_pkg::LED_MINUS;
                end else begin
                    // all three held: nothing to clear
                end
            end else if (rem_stat.fire) begin
                unique case (rcode)
                    dkmc_pkg::RCODE_START: begin
                        cmd = dkmc_pkg::CMD_START;
                    end
                    dkmc_pkg::RCODE_UP: begin
                        cmd      = dkmc_pkg::CMD_UP;
                        led_next = led_next | dkmc_pkg::LED_PLUS;
                    end
                    dkmc_pkg::RCODE_DOWN: begin
                        cmd      = dkmc_pkg::CMD_DOWN;
                        led_next = led_next | dkmc_pkg::LED_MINUS;
                    end
                    dkmc_pkg::RCODE_STOP: begin
                        cmd      = dkmc_pkg::CMD_STOP;
                        led_next = led_next | dkmc_pkg::LED_STOP;
                    end
                    default: ;
                endcase
            end
        end

        // while stopped only start gets through
        if (!(stopped_reg && (cmd != dkmc_pkg::CMD_START))) begin
            unique case (cmd)
                dkmc_pkg::CMD_START: begin
                    stopped_next = 1'b0;
                    mode_next    = 5'd1;
                    led_next     = led_next | dkmc_pkg::LED_RUN;
                end
                dkmc_pkg::CMD_STOP: begin
                    stopped_next = 1'b1;
                    led_next     = led_next & ~(dkmc_pkg::LED_RUN | dkmc_pkg::LED_PLUS
                                                | dkmc_pkg::LED_MINUS);
                end
                dkmc_pkg::CMD_UP: begin
                    mode_next = (mode_reg >= MODE_MAX) ? 5'd1 : mode_reg + 5'd1;
                end
                dkmc_pkg::CMD_DOWN: begin
                    mode_next = (mode_reg <= 5'd1) ? MODE_MAX : mode_reg - 5'd1;
                end
                default: ;
            endcase
        end

        // run LED is refreshed every tick in mode one while running
        if (!stopped_next && (mode_next == 5'd1)) begin
            led_next = led_next | dkmc_pkg::LED_RUN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            led_reg     <= dkmc_pkg::LED_RESET;
            mode_reg    <= 5'd1;
            stopped_reg <= 1'b0;
        end else if (step) begin
            led_reg     <= led_next;
            mode_reg    <= mode_next;
            stopped_reg <= stopped_next;
        end
    end

    // ---------------- result register ----------------
    logic [3:0]  leds_out_reg;
    logic [15:0] drive_out_reg;
    logic [4:0]  mode_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            leds_out_reg  <= led_next;
            drive_out_reg <= stopped_next ? 16'h0000
                                          : dkmc_pkg::mode_pattern(4'(mode_next - 5'd1));
            mode_out_reg  <= stopped_next ? 5'd0 : mode_next;
        end
    end

    assign m_key_leds      = leds_out_reg;
    assign m_channel_drive = drive_out_reg;
    assign m_current_mode  = mode_out_reg;

`ifndef SYNTHESIS
    // mode stays within 1..MODE_COUNT whatever command sequence arrives
    a_mode_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg >= 5'd1) && (mode_reg <= MODE_MAX))
        else $error("mode out of range");

    // every accepted tick leaves a result behind
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> m_valid_reg)
        else $error("tick accepted without result");

    // a stopped result never drives any channel
    a_stopped_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (mode_out_reg == 5'd0)) |-> (drive_out_reg == 16'h0000))
        else $error("channels driven while stopped");

    // run LED set whenever running in mode one
    a_run_led: assert property (@(posedge aclk) disable iff (!aresetn)
        (!stopped_reg && (mode_reg == 5'd1)) |-> led_reg[3])
        else $error("run LED missing in mode one");

    // remote state cannot move on a tick where a button fired
    a_remote_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && any_fire) |=> (rem_stat.lock_cur == $past(rem_stat.lock_cur)))
        else $error("remote changed on button tick");
`endif

endmodule

// ===== rtl/dkmc_debounce.sv =====
// ----------------------------------------------------------------------------
// dkmc_debounce - lock-until-release debounce counter
// Counts active ticks up to the threshold, fires once, then holds until release.
// ----------------------------------------------------------------------------
module dkmc_debounce (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,       // tick accepted
    input  logic                        active,     // input pressed this tick
    input  logic                        hold,       // leave state untouched
    input  logic [dkmc_pkg::CNT_W-1:0]  threshold,
    output dkmc_pkg::deb_stat_t         stat
);

    logic [dkmc_pkg::CNT_W-1:0] count_reg, count_next;
    logic                       lock_reg, lock_next;
    logic [dkmc_pkg::CNT_W-1:0] count_inc;

    assign count_inc = (count_reg == dkmc_pkg::CNT_MAX) ? count_reg
                                                        : count_reg + dkmc_pkg::CNT_W'(1);

    always_comb begin
        count_next = count_reg;
        lock_next  = lock_reg;
        stat.fire  = 1'b0;
        if (!hold) begin
            if (!active) begin
                count_next = '0;
                lock_next  = 1'b0;
            end else if (!lock_reg) begin
                count_next = count_inc;
                if (count_inc >= threshold) begin
                    lock_next = 1'b1;
                    stat.fire = 1'b1;
                end
            end
        end
        stat.lock_cur = lock_reg;
        stat.lock_nxt = lock_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            lock_reg  <= 1'b0;
        end else if (step) begin
            count_reg <= count_next;
            lock_reg  <= lock_next;
        end
    end

endmodule

// ===== verif/dkmc_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// dkmc_tb_pkg - tick predictor and result scoreboard for the key mode block
// Tracks debounce counters, locks, run/stop and mode from each input transfer,
// queues the expected LED / channel / mode result and checks result transfers.
// ----------------------------------------------------------------------------
package dkmc_tb_pkg;

    import dkmc_pkg::*;

    localparam int MODE_COUNT = 16;

    typedef struct packed {
        logic [3:0]  leds;
        logic [15:0] drive;
        logic [4:0]  mode;
    } tick_result_t;

    class key_mode_scoreboard;

        logic [9:0]   debounce_ticks;
        logic [9:0]   btn_cnt [4];
        logic         btn_lock [4];
        logic [9:0]   rem_cnt;
        logic         rem_lock;
        logic [4:0]   mode;
        logic         stopped;
        logic [3:0]   leds;
        tick_result_t pending [$];
        int           errors;
        int           checked;

        // per button, in start/stop/up/down order
        logic [3:0] btn_led [4] = '{LED_NONE, LED_STOP, LED_PLUS, LED_MINUS};
        cmd_t       btn_cmd [4] = '{CMD_START, CMD_STOP, CMD_UP, CMD_DOWN};

        logic [3:0] remote_map [16] = '{
            4'd0, 4'd1, 4'd2, 4'd10, 4'd3, 4'd15, 4'd6, 4'd7,
            4'd14, 4'd9, 4'd4, 4'd5, 4'd8, 4'd12, 4'd11, 4'd13
        };

        logic [15:0] pattern [16] = '{
            16'h0005, 16'h0010, 16'h000A, 16'h0020, 16'h0005, 16'h0040,
            16'h000A, 16'h0020, 16'h0081, 16'h0200, 16'h0102, 16'h0400,
            16'h0081, 16'h0800, 16'h0101, 16'h0400
        };

        function new();
            debounce_ticks = DEBOUNCE_RESET;
            for (int i = 0; i < 4; i++) begin
                btn_cnt[i]  = '0;
                btn_lock[i] = 1'b0;
            end
            rem_cnt  = '0;
            rem_lock = 1'b0;
            mode     = 5'd1;
            stopped  = 1'b0;
            leds     = LED_RESET;
            errors   = 0;
            checked  = 0;
        endfunction

        // keys_n: bit i is button i, low when pressed
        function void note_tick(input logic [3:0] keys_n, input logic [3:0] nib);
            cmd_t         cmd;
            logic         fired;
            logic         rem_lock_was;
            logic [4:0]   idx;
            tick_result_t r;
            cmd          = CMD_NONE;
            fired        = 1'b0;
            rem_lock_was = rem_lock;

            for (int i = 0; i < 4; i++) begin
                if (keys_n[i]) begin
                    btn_lock[i] = 1'b0;
                    btn_cnt[i]  = '0;
                    if (!rem_lock_was)
                        leds &= ~btn_led[i];
                end else if (!btn_lock[i]) begin
                    btn_cnt[i] = (btn_cnt[i] == CNT_MAX) ? CNT_MAX : btn_cnt[i] + 10'd1;
                    if (btn_cnt[i] >= debounce_ticks) begin
                        btn_lock[i] = 1'b1;
                        cmd         = btn_cmd[i];
                        fired       = 1'b1;
                        leds       |= btn_led[i];
                    end
                end
            end

            // remote only looked at when no button fired
            if (!fired) begin
                if (nib == 4'd0) begin
                    rem_lock = 1'b0;
                    rem_cnt  = '0;
                    if (!btn_lock[BTN_STOP])
                        leds &= ~LED_STOP;
                    else if (!btn_lock[BTN_UP])
                        leds &= ~LED_PLUS;
                    else if (!btn_lock[BTN_DOWN])
                        leds &= ~LED_MINUS;
                end else if (!rem_lock) begin
                    rem_cnt = (rem_cnt == CNT_MAX) ? CNT_MAX : rem_cnt + 10'd1;
                    if (rem_cnt >= debounce_ticks) begin
                        rem_lock = 1'b1;
                        case (remote_map[nib])
                            RCODE_START: cmd = CMD_START;
                            RCODE_UP: begin
                                cmd   = CMD_UP;
                                leds |= LED_PLUS;
                            end
                            RCODE_DOWN: begin
                                cmd   = CMD_DOWN;
                                leds |= LED_MINUS;
                            end
                            RCODE_STOP: begin
                                cmd   = CMD_STOP;
                                leds |= LED_STOP;
                            end
                            default: ;
                        endcase
                    end
                end
            end

            // stopped: only start gets through
            if (cmd != CMD_NONE && !(stopped && cmd != CMD_START)) begin
                case (cmd)
                    CMD_START: begin
                        stopped = 1'b0;
                        mode    = 5'd1;
                        leds   |= LED_RUN;
                    end
                    CMD_STOP: begin
                        stopped = 1'b1;
                        leds   &= ~(LED_MINUS | LED_PLUS | LED_RUN);
                    end
                    CMD_UP:   mode = (mode >= 5'(MODE_COUNT)) ? 5'd1 : mode + 5'd1;
                    CMD_DOWN: mode = (mode <= 5'd1) ? 5'(MODE_COUNT) : mode - 5'd1;
                    default: ;
                endcase
            end

            if (!stopped && mode == 5'd1)
                leds |= LED_RUN;

            idx     = mode - 5'd1;
            r.leds  = leds;
            r.drive = stopped ? 16'h0000 : pattern[idx[3:0]];
            r.mode  = stopped ? 5'd0 : mode;
            pending.push_back(r);
        endfunction

        task report_error(input string msg);
            $display("ERROR: %s", msg);
            errors++;
        endtask

        task check_result(input logic [3:0] got_leds, input logic [15:0] got_drive,
                          input logic [4:0] got_mode);
            tick_result_t want;
            if (pending.size() == 0) begin
                report_error($sformatf("result transfer with nothing expected: leds %h drive %h mode %0d",
                                       got_leds, got_drive, got_mode));
                return;
            end
            want = pending.pop_front();
            if (got_leds !== want.leds)
                report_error($sformatf("tick %0d key_leds %h, expected %h",
                                       checked, got_leds, want.leds));
            if (got_drive !== want.drive)
                report_error($sformatf("tick %0d channel_drive %h, expected %h",
                                       checked, got_drive, want.drive));
            if (got_mode !== want.mode)
                report_error($sformatf("tick %0d current_mode %0d, expected %0d",
                                       checked, got_mode, want.mode));
            checked++;
        endtask

    endclass

endpackage

// ===== verif/tb_debounced_key_mode_controller_top.sv =====
// ----------------------------------------------------------------------------
// tb_debounced_key_mode_controller_top - testbench for the key mode controller
// Drives millisecond ticks (buttons and remote nibble) over the s_ channel,
// takes results from the m_ channel with random stalls, and compares each one
// with a cycle-free predictor kept in the scoreboard. The debounce threshold
// is moved through several settings over the APB port, extremes included.
// ----------------------------------------------------------------------------
module tb_debounced_key_mode_controller_top;

    import dkmc_pkg::*;
    import dkmc_tb_pkg::*;

    // Tick word layout used by the stimulus:
    //   [7] start_n  [6] stop_n  [5] up_n  [4] down_n  [3:0] remote nibble
    localparam logic [7:0] KEYS_IDLE = 8'hF0;

    // remote nibbles that decode to commands
    localparam logic [3:0] NIB_START = 4'd1;
    localparam logic [3:0] NIB_UP    = 4'd2;
    localparam logic [3:0] NIB_DOWN  = 4'd4;
    localparam logic [3:0] NIB_STOP  = 4'd10;

    localparam int NUM_PHASES   = 7;
    localparam int HOLD_CYCLES  = 200;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;

    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic        s_start_key_n   = 1'b1;
    logic        s_stop_key_n    = 1'b1;
    logic        s_up_key_n      = 1'b1;
    logic        s_down_key_n    = 1'b1;
    logic [3:0]  s_remote_nibble = 4'd0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_key_leds;
    logic [15:0] m_channel_drive;
    logic [4:0]  m_current_mode;

    // pacing controls, set by the main sequence
    logic        tx_steady = 1'b0;  // sender offers back to back
    logic        rx_steady = 1'b0;  // receiver never stalls
    logic        hold_req  = 1'b0;  // receiver: one long hold-off

    key_mode_scoreboard sb = new();

    // Directed ticks, run with a zero debounce so that every active
    // input fires on its first tick.
    logic [7:0] directed_ticks [27] = '{
        8'hF0,  // all released
        8'hD0,  // up: mode 2
        8'hD0,  // up held: locked, nothing
        8'hF0,
        8'hE0,  // down: back to mode 1, run LED kept
        8'hF0,
        8'hE0,  // down from 1 wraps to the top mode
        8'hF0,
        8'hD0,  // up from the top wraps to 1
        8'h00,  // all four at once: LEDs set, down wins
        8'hF0,
        8'hB0,  // stop
        8'hF0,
        8'hD0,  // up while stopped: dropped, plus LED still lit
        8'hF1,  // remote start
        8'hF0,
        8'hF2,  // remote up
        8'hF2,  // held: remote locked
        8'hF4,  // nibble changes while locked: still nothing
        8'hF0,
        8'hF4,  // remote down
        8'hF0,
        8'hFA,  // remote stop
        8'h7F,  // start button with remote held: remote not examined
        8'hFF,  // remote code with no command
        8'hFF,
        8'hF0
    };

    int unsigned phase_debounce [NUM_PHASES] = '{1, 3, 2, 20, 1023, 5, 1};
    int          phase_ticks    [NUM_PHASES] = '{300, 250, 200, 350, 60, 200, 150};

    debounced_key_mode_controller_top #(
        .MODE_COUNT(MODE_COUNT)
    ) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_start_key_n   (s_start_key_n),
        .s_stop_key_n    (s_stop_key_n),
        .s_up_key_n      (s_up_key_n),
        .s_down_key_n    (s_down_key_n),
        .s_remote_nibble (s_remote_nibble),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_key_leds      (m_key_leds),
        .m_channel_drive (m_channel_drive),
        .m_current_mode  (m_current_mode)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Hard stop well beyond the slowest legal run: ~1550 ticks, each with
    // random idle gaps on either side, plus one long hold-off.
    initial begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

    // Transfer monitor: both channels sampled on the rising edge. Inputs
    // are noted before results are checked, so the order holds even if a
    // result and an input share an edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_tick({s_down_key_n, s_up_key_n, s_stop_key_n, s_start_key_n},
                             s_remote_nibble);
            if (m_valid && m_ready)
                sb.check_result(m_key_leds, m_channel_drive, m_current_mode);
        end
    end

    // Result side. One stall draw per result; a hold-off request from the
    // main sequence blocks the channel for a long counted stretch so that
    // the output register fills and s_ready has to drop.
    initial begin
        int gap;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                gap = rx_steady ? 0 : $urandom_range(0, 19);
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
                m_ready <= 1'b1;
                do @(posedge aclk); while (!m_valid);
                @(negedge aclk);
            end
        end
    end

    // One tick transfer. The idle gap comes first; valid then stays up
    // with a fixed payload until the handshake completes.
    task automatic send_tick(input logic [7:0] keys);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid         <= 1'b1;
        s_start_key_n   <= keys[7];
        s_stop_key_n    <= keys[6];
        s_up_key_n      <= keys[5];
        s_down_key_n    <= keys[4];
        s_remote_nibble <= keys[3:0];
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic drain;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // One APB transfer: setup, access, done on the edge with pready high.
    task automatic apb_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {REG_DEBOUNCE, 2'b00};
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_debounce_reg;
        logic [31:0] rd;
        apb_access(1'b0, 32'd0, rd);
        if (rd !== {22'd0, sb.debounce_ticks})
            sb.report_error($sformatf("debounce_ticks reads %h, expected %h",
                                      rd, sb.debounce_ticks));
    endtask

    task automatic set_debounce(input logic [9:0] value);
        logic [31:0] rd;
        apb_access(1'b1, {22'd0, value}, rd);
        sb.debounce_ticks = value;
        check_debounce_reg();
    endtask

    // Random phase. Mostly clean presses held around the threshold (some
    // a tick short) followed by a release, so commands really fire and
    // the mode walks and wraps; the rest is raw noise on all inputs.
    // Above a practical hold length only short presses are made.
    task automatic run_phase(input int unsigned thr, input int budget);
        int         sent;
        int         hold;
        int         rel;
        int         src;
        logic [7:0] keys;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(0, 9) < 7) begin
                keys = KEYS_IDLE;
                src  = $urandom_range(0, 9);
                case (src)
                    0:       keys[7] = 1'b0;
                    1:       keys[6] = 1'b0;
                    2, 3:    keys[5] = 1'b0;
                    4, 5:    keys[4] = 1'b0;
                    default: begin
                        case ($urandom_range(0, 7))
                            0:       keys[3:0] = NIB_START;
                            1:       keys[3:0] = NIB_UP;
                            2:       keys[3:0] = NIB_DOWN;
                            3:       keys[3:0] = NIB_STOP;
                            default: keys[3:0] = 4'($urandom_range(1, 15));
                        endcase
                    end
                endcase
                if (thr <= 40)
                    hold = $urandom_range((thr > 1) ? thr - 1 : 1, thr + 3);
                else
                    hold = $urandom_range(1, 40);
                repeat (hold) send_tick(keys);
                rel = $urandom_range(1, 3);
                repeat (rel) send_tick(KEYS_IDLE);
                sent += hold + rel;
            end else begin
                rel = $urandom_range(1, 4);
                repeat (rel) send_tick(8'($urandom));
                sent += rel;
            end
        end
    endtask

    initial begin
        // reset held from the start, released on a falling edge
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // threshold must read back at its reset value
        check_debounce_reg();

        // directed part with a zero threshold
        set_debounce(10'd0);
        foreach (directed_ticks[i])
            send_tick(directed_ticks[i]);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_debounce(10'(phase_debounce[p]));
            tx_steady = (p % 2 == 1);
            rx_steady = (p % 3 == 1);
            // second phase: sender back to back while the receiver holds off
            if (p == 1)
                hold_req = 1'b1;
            run_phase(phase_debounce[p], phase_ticks[p]);
            drain();
        end

        repeat (5) @(posedge aclk);
        if (sb.pending.size() != 0)
            sb.report_error($sformatf("%0d expected results never arrived",
                                      sb.pending.size()));

        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
